// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file wua128_chk.
// Each macro takes a label, an antecedent, a consequent and a message.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define WUA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define WUA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/wua128_pkg.sv =====
// Package for the 128-bit unsigned ALU: opcodes, the pipeline stage type
// and the per-stage functions. No dependencies.
`default_nettype none
package wua128_pkg;

	localparam int DW = 128;
	localparam int HW = 64;
	localparam int DIV_STAGES = 128;
	localparam int MUL_STAGE = 3;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_CMP = 3'd2;
	localparam logic [2:0] OP_MUL = 3'd3;
	localparam logic [2:0] OP_DIV = 3'd4;
	localparam logic [2:0] OP_REM = 3'd5;

	localparam logic [1:0] ORD_LT = 2'b11;
	localparam logic [1:0] ORD_EQ = 2'b00;
	localparam logic [1:0] ORD_GT = 2'b01;

	// One transaction as it moves down the pipeline.
	typedef struct packed {
		logic          valid;
		logic [2:0]    op;
		logic [DW-1:0] rem;
		logic [DW-1:0] quo;
		logic [DW-1:0] d;
		logic [DW-1:0] res;
		logic [1:0]    ord;
		logic          zd;
	} stage_t;

	// Partial products of the multiply path.
	typedef struct packed {
		logic [63:0] p00;
		logic [63:0] p01;
		logic [63:0] p10;
		logic [63:0] p11;
		logic [63:0] h00;
		logic [31:0] h01;
		logic [31:0] h10;
	} prod_t;

	typedef struct packed {
		logic [DW-1:0] base;
		logic [64:0]   mid;
		logic [63:0]   hi;
	} psum_t;

	// One restoring division step: shift in the next dividend bit and
	// subtract the divisor when the partial remainder covers it.
	function automatic stage_t div_step(stage_t x);
		stage_t       y;
		logic [DW:0]  sh;
		logic [DW+1:0] diff;
		logic          ge;
		y    = x;
		sh   = {x.rem, x.quo[DW-1]};
		diff = {1'b0, sh} - {2'b00, x.d};
		ge   = ~diff[DW+1];
		y.rem = ge ? diff[DW-1:0] : sh[DW-1:0];
		y.quo = {x.quo[DW-2:0], ge};
		return y;
	endfunction

	// Add, subtract and compare; zero for every other opcode.
	function automatic logic [DW+1:0] fast_op(logic [2:0] op, logic [DW-1:0] a,
			logic [DW-1:0] b);
		logic [DW-1:0] r;
		logic [1:0]    o;
		r = '0;
		o = ORD_EQ;
		if (op == OP_ADD) begin
			r = a + {{HW{1'b0}}, b[HW-1:0]};
		end else if (op == OP_SUB) begin
			r = a - b;
		end else if (op == OP_CMP) begin
			if (a > b) o = ORD_GT;
			else if (a < b) o = ORD_LT;
		end
		return {r, o};
	endfunction

endpackage
`default_nettype wire

// ===== hdl/wua128_req_if.sv =====
// Request channel of the 128-bit unsigned ALU: handshake and operands.
// No dependencies.
`default_nettype none
interface wua128_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [63:0] a_low;
	logic [63:0] a_high;
	logic [63:0] b_low;
	logic [63:0] b_high;

	modport source(output valid, opcode, a_low, a_high, b_low, b_high, input ready);
	modport sink(input valid, opcode, a_low, a_high, b_low, b_high, output ready);
endinterface
`default_nettype wire

// ===== hdl/wua128_rsp_if.sv =====
// Response channel of the 128-bit unsigned ALU: handshake and results.
// No dependencies.
`default_nettype none
interface wua128_rsp_if;
	logic              valid;
	logic              ready;
	logic [63:0]       result_low;
	logic [63:0]       result_high;
	logic signed [1:0] order;
	logic              zero_divisor;

	modport source(output valid, result_low, result_high, order, zero_divisor, input ready);
	modport sink(input valid, result_low, result_high, order, zero_divisor, output ready);
endinterface
`default_nettype wire

// ===== hdl/wide_unsigned_alu_128_top.sv =====
// Top level of the 128-bit unsigned ALU pipeline.
// Depends on wua128_pkg, wua128_req_if and wua128_rsp_if.
//
//   Channel  Role    Carries
//   req      sink    opcode, a_low, a_high, b_low, b_high
//   rsp      source  result_low, result_high, order, zero_divisor
//
// Every transaction passes the input stage, which loads at the accepting edge, then
// 128 division stages with one quotient bit per stage, then the output register.
// One transaction is accepted per cycle while the pipeline advances.
// The whole pipeline advances together; it holds only while a result waits
// in the output register and rsp.ready is low. Reset clears all valid bits.
`default_nettype none
module wide_unsigned_alu_128_top (
	input  wire logic  clk,
	input  wire logic  arst_n,
	wua128_req_if.sink   req,
	wua128_rsp_if.source rsp
);
	import wua128_pkg::*;

	wua128_pkg::stage_t div_s [0:DIV_STAGES];
	prod_t              mul_s2;
	psum_t              mul_s3;
	logic               adv;
	logic [DW-1:0]      res_q;
	logic [1:0]         ord_q;
	logic               zd_q;
	logic               vld_q;

	// The pipeline moves whenever the output register is free or drained.
	assign adv       = ~vld_q | rsp.ready;
	assign req.ready = adv;

	// Input stage: operands are loaded as dividend and divisor.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s[0] <= '0;
		end else if (adv) begin
			div_s[0].valid <= req.valid;
			div_s[0].op    <= req.opcode;
			div_s[0].rem   <= '0;
			div_s[0].quo   <= {req.a_high, req.a_low};
			div_s[0].d     <= (req.opcode == OP_DIV) ? {{HW{1'b0}}, req.b_low}
				: {req.b_high, req.b_low};
			div_s[0].res   <= '0;
			div_s[0].ord   <= ORD_EQ;
			div_s[0].zd    <= ((req.opcode == OP_DIV) && (req.b_low == '0))
				|| ((req.opcode == OP_REM) && (req.b_low == '0) && (req.b_high == '0));
		end
	end

	// Multiply: 32 by 32 partial products, then partial sums.
	always_ff @(posedge clk) begin
		if (adv) begin
			mul_s2.p00 <= 64'(div_s[0].quo[31:0]  * div_s[0].d[31:0]);
			mul_s2.p01 <= 64'(div_s[0].quo[31:0]  * div_s[0].d[63:32]);
			mul_s2.p10 <= 64'(div_s[0].quo[63:32] * div_s[0].d[31:0]);
			mul_s2.p11 <= 64'(div_s[0].quo[63:32] * div_s[0].d[63:32]);
			mul_s2.h00 <= 64'(div_s[0].quo[95:64] * div_s[0].d[31:0]);
			mul_s2.h01 <= 32'(div_s[0].quo[95:64] * div_s[0].d[63:32]);
			mul_s2.h10 <= 32'(div_s[0].quo[127:96] * div_s[0].d[31:0]);
			mul_s3.base <= {mul_s2.p11, mul_s2.p00};
			mul_s3.mid  <= {1'b0, mul_s2.p01} + {1'b0, mul_s2.p10};
			mul_s3.hi   <= mul_s2.h00 + {(mul_s2.h01 + mul_s2.h10), 32'h0};
		end
	end

	// Division stages; add, subtract and compare results join at stage one,
	// the product at the multiply stage.
	for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			stage_t nxt;
			if (!arst_n) begin
				div_s[k] <= '0;
			end else if (adv) begin
				nxt = div_step(div_s[k-1]);
				if (k == 1) begin
					{nxt.res, nxt.ord} = fast_op(div_s[k-1].op,
						div_s[k-1].quo, div_s[k-1].d);
				end
				if ((k == MUL_STAGE) && (div_s[k-1].op == OP_MUL)) begin
					nxt.res = mul_s3.base + {31'h0, mul_s3.mid, 32'h0}
						+ {mul_s3.hi, 64'h0};
				end
				div_s[k] <= nxt;
			end
		end
	end

	// Output register: pick the quotient, remainder or early result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= div_s[DIV_STAGES].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ord_q <= div_s[DIV_STAGES].ord;
			zd_q  <= div_s[DIV_STAGES].zd;
			if (div_s[DIV_STAGES].op == OP_DIV) begin
				res_q <= div_s[DIV_STAGES].zd ? '1 : div_s[DIV_STAGES].quo;
			end else if (div_s[DIV_STAGES].op == OP_REM) begin
				res_q <= div_s[DIV_STAGES].zd ? '0 : div_s[DIV_STAGES].rem;
			end else begin
				res_q <= div_s[DIV_STAGES].res;
			end
		end
	end

	assign rsp.valid        = vld_q;
	assign rsp.result_low   = res_q[HW-1:0];
	assign rsp.result_high  = res_q[DW-1:HW];
	assign rsp.order        = ord_q;
	assign rsp.zero_divisor = zd_q;

endmodule
`default_nettype wire

// ===== hdl/wua128_chk.sv =====
// Port checker for the 128-bit unsigned ALU, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module wua128_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [63:0] result_low,
	input wire logic [63:0] result_high,
	input wire logic [1:0]  order,
	input wire logic        zero_divisor
);
	// A stalled result transaction keeps its payload.
	`WUA_ASSERT_NEXT(a_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(result_low) && $stable(result_high), "rsp payload changed under stall")
	// A compare outcome comes with a zero result.
	`WUA_ASSERT_NOW(a_cmp_zero, rsp_valid && (order != 2'b00), (result_low == 64'h0) && (result_high == 64'h0), "compare with nonzero result")
	// Compare and zero divisor never show together.
	`WUA_ASSERT_NOW(a_excl, rsp_valid && zero_divisor, order == 2'b00, "zero divisor with compare outcome")
	// The order code -2 is never produced.
	`WUA_ASSERT_NOW(a_ord, rsp_valid, order != 2'b10, "illegal order code")
endmodule

bind wide_unsigned_alu_128_top wua128_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.result_low(rsp.result_low),
	.result_high(rsp.result_high),
	.order(rsp.order),
	.zero_divisor(rsp.zero_divisor)
);
`default_nettype wire
